FILE: hdl/ipac_pkg.sv
// Shared types and constants for the IP address text classifier.
package ipac_pkg;

  // Character queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  // Result queue at the back end (depth is a power of two)
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // ASCII codes
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // IPv4 limits
  localparam logic [1:0]  V4_MAX_DIGITS = 2'd3;
  localparam logic [1:0]  V4_DOTS       = 2'd3;
  localparam logic [11:0] V4_MAX_VALUE  = 12'd255;

  // IPv6 limits
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [2:0] V6_COLONS     = 3'd7;

  // Result codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_V4   = 2'd1,
    KIND_V6   = 2'd2
  } kind_t;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Classified character handed from front to back
  typedef struct packed {
    logic       is_dec;
    logic [3:0] dec_val;
    logic       is_hex;
    logic       is_dot;
    logic       is_colon;
    logic       last;
  } char_class_t;

endpackage

FILE: hdl/ipac_front.sv
// Front end: accepts characters and classifies them for the checkers.
module ipac_front import ipac_pkg::*; (
  input  logic        push,
  input  logic [7:0]  char_code,
  input  logic        is_last,
  input  logic        cq_full,
  output logic        full,
  output logic        cq_push,
  output char_class_t cq_item
);

  logic is_dec;
  logic is_lower_hex;
  logic is_upper_hex;

  // Decode the character class
  assign is_dec       = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_lower_hex = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
  assign is_upper_hex = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);

  always_comb begin
    cq_item          = '0;
    cq_item.is_dec   = is_dec;
    cq_item.dec_val  = 4'(char_code - CHAR_ZERO);
    cq_item.is_hex   = is_dec || is_lower_hex || is_upper_hex;
    cq_item.is_dot   = (char_code == CHAR_DOT);
    cq_item.is_colon = (char_code == CHAR_COLON);
    cq_item.last     = is_last;
  end

  // Hand the item on while the queue has room
  assign full    = cq_full;
  assign cq_push = push && !cq_full;

endmodule

FILE: hdl/ipac_cq.sv
// Short queue of classified characters between front and back.
module ipac_cq import ipac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  char_class_t wr_item,
  input  logic        rd_en,
  output char_class_t rd_item,
  output logic        valid,
  output logic        full
);

  char_class_t          mem [CQ_DEPTH];
  logic [CQ_AW-1:0]     head;
  logic [CQ_AW-1:0]     tail;
  logic [CQ_AW:0]       count;

  // Store an item at the tail
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= wr_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        tail <= tail + CQ_AW'(1);
      end
      if (rd_en) begin
        head <= head + CQ_AW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + (CQ_AW+1)'(1);
        2'b01:   count <= count - (CQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_item = mem[head];
  assign valid   = (count != '0);
  assign full    = (count == (CQ_AW+1)'(CQ_DEPTH));

endmodule

FILE: hdl/ipac_back.sv
// Back end: runs the IPv4 and IPv6 checkers and queues the verdicts.
module ipac_back import ipac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cq_valid,
  input  char_class_t cq_item,
  output logic        cq_pop,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  address_kind
);

  // Checker state
  logic        saw_dot,         saw_dot_next;
  logic [1:0]  v4_group_count,  v4_group_count_next;
  logic [1:0]  v4_digit_count,  v4_digit_count_next;
  logic [7:0]  v4_group_value,  v4_group_value_next;
  logic        v4_leading_zero, v4_leading_zero_next;
  logic        v4_failed,       v4_failed_next;
  logic [2:0]  v6_group_count,  v6_group_count_next;
  logic [2:0]  v6_digit_count,  v6_digit_count_next;
  logic        v6_failed,       v6_failed_next;

  logic [11:0] v4_sum;
  logic        v4_ok;
  logic        v6_ok;
  kind_t       kind;

  // Result queue
  kind_t            rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0] rq_head;
  logic [RQ_AW-1:0] rq_tail;
  logic [RQ_AW:0]   rq_count;
  logic             rq_push;
  logic             rq_pop;

  // Take a character unless it closes a string and no result slot is free
  assign cq_pop  = cq_valid && (!cq_item.last || (rq_count != (RQ_AW+1)'(RQ_DEPTH)));
  assign rq_push = cq_pop && cq_item.last;
  assign rq_pop  = pop && !empty;

  assign v4_sum = ({4'd0, v4_group_value} * 12'd10) + {8'd0, cq_item.dec_val};

  // Update both checkers for the current character
  always_comb begin
    saw_dot_next         = saw_dot;
    v4_group_count_next  = v4_group_count;
    v4_digit_count_next  = v4_digit_count;
    v4_group_value_next  = v4_group_value;
    v4_leading_zero_next = v4_leading_zero;
    v4_failed_next       = v4_failed;
    v6_group_count_next  = v6_group_count;
    v6_digit_count_next  = v6_digit_count;
    v6_failed_next       = v6_failed;

    if (cq_item.is_dot) begin
      saw_dot_next = 1'b1;
    end

    // IPv4: dotted decimal groups
    if (!v4_failed) begin
      if (cq_item.is_dec) begin
        if (v4_digit_count == V4_MAX_DIGITS) begin
          v4_failed_next = 1'b1;
        end else if ((v4_digit_count != 2'd0) && v4_leading_zero) begin
          v4_failed_next = 1'b1;
        end else if (v4_sum > V4_MAX_VALUE) begin
          v4_failed_next = 1'b1;
        end else begin
          v4_group_value_next = v4_sum[7:0];
          v4_digit_count_next = v4_digit_count + 2'd1;
          if (v4_digit_count == 2'd0) begin
            v4_leading_zero_next = (cq_item.dec_val == 4'd0);
          end
        end
      end else if (cq_item.is_dot) begin
        if ((v4_digit_count == 2'd0) || (v4_group_count == V4_DOTS)) begin
          v4_failed_next = 1'b1;
        end else begin
          v4_group_count_next  = v4_group_count + 2'd1;
          v4_digit_count_next  = 2'd0;
          v4_group_value_next  = 8'd0;
          v4_leading_zero_next = 1'b0;
        end
      end else begin
        v4_failed_next = 1'b1;
      end
    end

    // IPv6: colon separated hex groups
    if (!v6_failed) begin
      if (cq_item.is_hex) begin
        if (v6_digit_count == V6_MAX_DIGITS) begin
          v6_failed_next = 1'b1;
        end else begin
          v6_digit_count_next = v6_digit_count + 3'd1;
        end
      end else if (cq_item.is_colon) begin
        if ((v6_digit_count == 3'd0) || (v6_group_count == V6_COLONS)) begin
          v6_failed_next = 1'b1;
        end else begin
          v6_group_count_next = v6_group_count + 3'd1;
          v6_digit_count_next = 3'd0;
        end
      end else begin
        v6_failed_next = 1'b1;
      end
    end
  end

  // Pick the verdict from the updated state
  assign v4_ok = !v4_failed_next && (v4_group_count_next == V4_DOTS)
                 && (v4_digit_count_next != 2'd0);
  assign v6_ok = !v6_failed_next && (v6_group_count_next == V6_COLONS)
                 && (v6_digit_count_next != 3'd0);

  always_comb begin
    if (saw_dot_next) begin
      kind = v4_ok ? KIND_V4 : KIND_NONE;
    end else begin
      kind = v6_ok ? KIND_V6 : KIND_NONE;
    end
  end

  // Hold checker state; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst || rq_push) begin
      saw_dot         <= 1'b0;
      v4_group_count  <= '0;
      v4_digit_count  <= '0;
      v4_group_value  <= '0;
      v4_leading_zero <= 1'b0;
      v4_failed       <= 1'b0;
      v6_group_count  <= '0;
      v6_digit_count  <= '0;
      v6_failed       <= 1'b0;
    end else if (cq_pop) begin
      saw_dot         <= saw_dot_next;
      v4_group_count  <= v4_group_count_next;
      v4_digit_count  <= v4_digit_count_next;
      v4_group_value  <= v4_group_value_next;
      v4_leading_zero <= v4_leading_zero_next;
      v4_failed       <= v4_failed_next;
      v6_group_count  <= v6_group_count_next;
      v6_digit_count  <= v6_digit_count_next;
      v6_failed       <= v6_failed_next;
    end
  end

  // Store the verdict
  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_mem[rq_tail] <= kind;
    end
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_head  <= '0;
      rq_tail  <= '0;
      rq_count <= '0;
    end else begin
      if (rq_push) begin
        rq_tail <= rq_tail + RQ_AW'(1);
      end
      if (rq_pop) begin
        rq_head <= rq_head + RQ_AW'(1);
      end
      case ({rq_push, rq_pop})
        2'b10:   rq_count <= rq_count + (RQ_AW+1)'(1);
        2'b01:   rq_count <= rq_count - (RQ_AW+1)'(1);
        default: rq_count <= rq_count;
      endcase
    end
  end

  assign empty        = (rq_count == '0);
  assign address_kind = rq_mem[rq_head];

endmodule

FILE: hdl/ip_address_text_classifier_core.sv
// Usage
//   Input channel: drive char_code and is_last with push high; a character is
//   taken on a rising edge where push is high and full is low. Send an address
//   one ASCII character per item, with is_last set on its final character.
//   Result channel: while empty is low, address_kind holds the oldest verdict
//   (0 neither, 1 IPv4, 2 IPv6); it is removed on an edge where pop is high.
//   One verdict is given per string, none for other characters.
// Timing
//   A taken character passes the character queue register; the checkers and
//   the verdict write share the cycle in which the back end takes it from that
//   queue, and empty falls once the verdict is registered in the result queue.
//   Throughput: one character per cycle while no final character waits for a
//   result slot, set by the single checker update per cycle in the back end.
// Stalls and reset
//   When pop is held low, verdicts collect in a two-entry result queue;
//   characters inside a string still drain, and a final character waits at
//   the head of the four-entry character queue until a result slot frees;
//   full rises once that queue holds four characters.
//   rst (synchronous, active high) empties both queues and clears checker
//   state; no clearing pass is needed.
module ip_address_text_classifier_core import ipac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       is_last,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] address_kind
);

  logic        cq_full;
  logic        cq_push;
  char_class_t cq_wr_item;
  char_class_t cq_item;
  logic        cq_valid;
  logic        cq_pop;

  // Classify incoming characters
  ipac_front u_front (
    .push      (push),
    .char_code (char_code),
    .is_last   (is_last),
    .cq_full   (cq_full),
    .full      (full),
    .cq_push   (cq_push),
    .cq_item   (cq_wr_item)
  );

  // Decouple front from back
  ipac_cq u_cq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_push),
    .wr_item (cq_wr_item),
    .rd_en   (cq_pop),
    .rd_item (cq_item),
    .valid   (cq_valid),
    .full    (cq_full)
  );

  // Run the checkers and queue verdicts
  ipac_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cq_valid     (cq_valid),
    .cq_item      (cq_item),
    .cq_pop       (cq_pop),
    .pop          (pop),
    .empty        (empty),
    .address_kind (address_kind)
  );

`ifndef SYNTHESIS
  // A shown verdict is never the unused code
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (address_kind != KIND_UNUSED))
    else $error("unused verdict code shown");

  // Closing a string makes a verdict available next cycle
  assert property (@(posedge clk) disable iff (rst)
    (cq_pop && cq_item.last) |=> !empty)
    else $error("verdict missing after last character");

  // An accepted character is queued for the back end
  assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> cq_valid)
    else $error("accepted character not queued");

  // Characters inside a string never wait on the result side
  assert property (@(posedge clk) disable iff (rst)
    (cq_valid && !cq_item.last) |-> cq_pop)
    else $error("back end stalled inside a string");
`endif

endmodule

FILE: sim/tb_ip_address_text_classifier_core.sv
// Self-checking testbench for the IP address text classifier core.
`timescale 1ns / 100ps

module tb_ip_address_text_classifier_core import ipac_pkg::*;;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int MAX_IDLE      = 13;
  localparam int WANT_PREDICTED = -1;
  localparam int NO_NUL         = -1;

  // Ways in which a generated address departs from a well-formed one
  typedef enum int {
    FLAW_NONE,
    FLAW_FEW,
    FLAW_MANY,
    FLAW_BIG,
    FLAW_LEAD,
    FLAW_EMPTY,
    FLAW_TRAIL
  } flaw_t;

  typedef struct {
    string text;
    int    nul_at;
    int    want;
  } probe_row_t;

  // Directed addresses; a typed verdict where it is obvious, else predicted
  probe_row_t probes [25] = '{
    '{"0.0.0.0",                                 NO_NUL, KIND_V4},
    '{"255.255.255.255",                         NO_NUL, KIND_V4},
    '{"256.1.1.1",                               NO_NUL, KIND_NONE},
    '{"1.2.3",                                   NO_NUL, KIND_NONE},
    '{"1.2.3.4.5",                               NO_NUL, KIND_NONE},
    '{"01.2.3.4",                                NO_NUL, KIND_NONE},
    '{"0.10.100.199",                            NO_NUL, KIND_V4},
    '{"1..2.3",                                  NO_NUL, KIND_NONE},
    '{"1.2.3.",                                  NO_NUL, KIND_NONE},
    '{"1234.1.1.1",                              NO_NUL, KIND_NONE},
    '{"0.0.0.00",                                NO_NUL, KIND_NONE},
    '{"0:0:0:0:0:0:0:0",                         NO_NUL, KIND_V6},
    '{"ffff:FFFF:abcd:ABCD:0123:4567:89aB:cDeF", NO_NUL, KIND_V6},
    '{"1:2:3:4:5:6:7",                           NO_NUL, KIND_NONE},
    '{"1:2:3:4:5:6:7:8:9",                       NO_NUL, KIND_NONE},
    '{"1:2:3:4:5:6:7:",                          NO_NUL, KIND_NONE},
    '{"12345:1:1:1:1:1:1:1",                     NO_NUL, KIND_NONE},
    '{"1::2:3:4:5:6:7",                          NO_NUL, KIND_NONE},
    '{"g:0:0:0:0:0:0:0",                         NO_NUL, KIND_NONE},
    '{"1.2.3.4\n",                               NO_NUL, KIND_NONE},
    '{"1:2:3:4:5:6:7:8",                         3,      WANT_PREDICTED},
    '{"1:2:3:4.5:6:7:8",                         NO_NUL, WANT_PREDICTED},
    '{"A",                                       NO_NUL, WANT_PREDICTED},
    '{".",                                       NO_NUL, KIND_NONE},
    '{"x\377@/;G",                               NO_NUL, WANT_PREDICTED}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code = 8'h00;
  logic       is_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] address_kind;

  // Classifier state held by the predictor
  logic       dot_seen = 1'b0;
  logic [1:0] quad_dots = '0;
  logic [1:0] quad_digits = '0;
  logic [9:0] quad_value = '0;
  logic       quad_lead_zero = 1'b0;
  logic       quad_bad = 1'b0;
  logic [2:0] hex_colons = '0;
  logic [2:0] hex_digits = '0;
  logic       hex_bad = 1'b0;

  logic [1:0] verdict_q [$];
  logic [7:0] addr_chars [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         pop_hold = 0;
  logic       feed_steady = 1'b0;
  logic       drain_steady = 1'b0;
  logic [1:0] verdict_want;

  ip_address_text_classifier_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_code    (char_code),
    .is_last      (is_last),
    .empty        (empty),
    .pop          (pop),
    .address_kind (address_kind)
  );

  always #6 clk = ~clk;

  // Advance both checkers by one character; give the verdict on the last one
  task automatic classify_char(input logic [7:0] c, input logic last,
                               output logic done, output logic [1:0] kind);
    int   nv;
    logic is_d;
    logic is_h;
    is_d = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_h = is_d || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F));
    if (c == CHAR_DOT) dot_seen = 1'b1;

    // dotted decimal checker
    if (!quad_bad) begin
      if (is_d) begin
        nv = int'(quad_value) * 10 + (int'(c) - int'(CHAR_ZERO));
        if (quad_digits >= V4_MAX_DIGITS) begin
          quad_bad = 1'b1;
        end else if (quad_digits != 0 && quad_lead_zero) begin
          quad_bad = 1'b1;
        end else if (nv > int'(V4_MAX_VALUE)) begin
          quad_bad = 1'b1;
        end else begin
          if (quad_digits == 0) quad_lead_zero = (c == CHAR_ZERO);
          quad_value  = nv[9:0];
          quad_digits = quad_digits + 2'd1;
        end
      end else if (c == CHAR_DOT) begin
        if (quad_digits == 0 || quad_dots >= V4_DOTS) begin
          quad_bad = 1'b1;
        end else begin
          quad_dots      = quad_dots + 2'd1;
          quad_digits    = '0;
          quad_value     = '0;
          quad_lead_zero = 1'b0;
        end
      end else begin
        quad_bad = 1'b1;
      end
    end

    // colon hex checker
    if (!hex_bad) begin
      if (is_h) begin
        if (hex_digits >= V6_MAX_DIGITS) hex_bad = 1'b1;
        else hex_digits = hex_digits + 3'd1;
      end else if (c == CHAR_COLON) begin
        if (hex_digits == 0 || hex_colons >= V6_COLONS) begin
          hex_bad = 1'b1;
        end else begin
          hex_colons = hex_colons + 3'd1;
          hex_digits = '0;
        end
      end else begin
        hex_bad = 1'b1;
      end
    end

    done = last;
    kind = KIND_NONE;
    if (last) begin
      if (dot_seen) begin
        if (!quad_bad && quad_dots == V4_DOTS && quad_digits != 0) kind = KIND_V4;
      end else begin
        if (!hex_bad && hex_colons == V6_COLONS && hex_digits != 0) kind = KIND_V6;
      end
      // clear for the next address
      dot_seen       = 1'b0;
      quad_dots      = '0;
      quad_digits    = '0;
      quad_value     = '0;
      quad_lead_zero = 1'b0;
      quad_bad       = 1'b0;
      hex_colons     = '0;
      hex_digits     = '0;
      hex_bad        = 1'b0;
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) addr_chars.push_back(s.getc(i));
  endtask

  // Build a dotted decimal address, possibly with one flaw
  task automatic build_quad();
    flaw_t flaw;
    int    groups;
    int    bad;
    flaw = $urandom_range(0, 1) ? FLAW_NONE : flaw_t'($urandom_range(FLAW_FEW, FLAW_TRAIL));
    groups = 4;
    if (flaw == FLAW_FEW) groups = $urandom_range(1, 3);
    if (flaw == FLAW_MANY) groups = $urandom_range(5, 6);
    bad = $urandom_range(0, groups - 1);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) addr_chars.push_back(CHAR_DOT);
      if (g == bad && flaw == FLAW_BIG) begin
        put_text($sformatf("%0d", $urandom_range(256, 9999)));
      end else if (g == bad && flaw == FLAW_LEAD) begin
        put_text($sformatf("0%0d", $urandom_range(0, 99)));
      end else if (!(g == bad && flaw == FLAW_EMPTY)) begin
        case ($urandom_range(0, 2))
          0:       put_text($sformatf("%0d", $urandom_range(0, 9)));
          1:       put_text($sformatf("%0d", $urandom_range(10, 99)));
          default: put_text($sformatf("%0d", $urandom_range(100, 255)));
        endcase
      end
    end
    if (flaw == FLAW_TRAIL) addr_chars.push_back(CHAR_DOT);
  endtask

  // Build a colon hex address, possibly with one flaw
  task automatic build_hex();
    string digits_set;
    flaw_t flaw;
    int    groups;
    int    bad;
    int    digits;
    digits_set = "0123456789abcdefABCDEF";
    flaw = $urandom_range(0, 1) ? FLAW_NONE : flaw_t'($urandom_range(FLAW_FEW, FLAW_TRAIL));
    groups = 8;
    if (flaw == FLAW_FEW) groups = $urandom_range(1, 7);
    if (flaw == FLAW_MANY) groups = $urandom_range(9, 10);
    bad = $urandom_range(0, groups - 1);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) addr_chars.push_back(CHAR_COLON);
      digits = $urandom_range(1, 4);
      if (g == bad) begin
        case (flaw)
          FLAW_BIG:   digits = $urandom_range(5, 6);
          FLAW_LEAD:  digits = 4;
          FLAW_EMPTY: digits = 0;
          default:    ;
        endcase
      end
      for (int d = 0; d < digits; d++)
        addr_chars.push_back(digits_set.getc($urandom_range(0, 21)));
    end
    if (flaw == FLAW_TRAIL) addr_chars.push_back(CHAR_COLON);
  endtask

  // Feed one address, item by item, with random gaps; queue its verdict
  task automatic send_address(input logic [7:0] chars [$], input int want);
    int         gap;
    logic       done;
    logic [1:0] kind;
    logic       last;
    foreach (chars[i]) begin
      last = (i == chars.size() - 1);
      gap = feed_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      push      <= 1'b1;
      char_code <= chars[i];
      is_last   <= last;
      @(posedge clk);
      while (full) @(posedge clk);
      classify_char(chars[i], last, done, kind);
      if (done) verdict_q.push_back((want == WANT_PREDICTED) ? kind : want[1:0]);
      if ($urandom_range(0, 40) == 0) feed_steady = !feed_steady;
    end
  endtask

  // Take verdicts with random stalls and check each against the oldest expected
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          $error("address_kind: expected none, actual %0d", address_kind);
          mismatch_count++;
        end else begin
          verdict_want = verdict_q.pop_front();
          if (address_kind !== verdict_want) begin
            $error("address_kind: expected %0d, actual %0d", verdict_want, address_kind);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 20) == 0) drain_steady = !drain_steady;
        pop_hold = drain_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (pop_hold != 0) pop <= 1'b0;
      end else if (!pop) begin
        if (pop_hold == 0) pop <= 1'b1;
        else pop_hold--;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int chars_sent;
    int len;
    string noise_set;
    chars_sent = 0;
    noise_set = "0123456789.:abcdefABCDEFgG /\n";

    // hold reset, then release
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed addresses
    foreach (probes[r]) begin
      addr_chars.delete();
      put_text(probes[r].text);
      if (probes[r].nul_at != NO_NUL) addr_chars[probes[r].nul_at] = 8'h00;
      send_address(addr_chars, probes[r].want);
    end

    // random addresses: mostly well-formed shapes, some noise
    while (chars_sent < RANDOM_ITEMS) begin
      addr_chars.delete();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: build_quad();
        4, 5, 6, 7: build_hex();
        8: begin
          len = $urandom_range(1, 16);
          repeat (len) addr_chars.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          len = $urandom_range(1, 20);
          repeat (len) addr_chars.push_back(noise_set.getc($urandom_range(0, noise_set.len() - 1)));
        end
      endcase
      if (addr_chars.size() == 0) addr_chars.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0)
        addr_chars[$urandom_range(0, addr_chars.size() - 1)] = 8'($urandom_range(0, 255));
      send_address(addr_chars, WANT_PREDICTED);
      chars_sent += addr_chars.size();
    end
    push <= 1'b0;

    // drain outstanding verdicts, then watch for strays
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: ip_address_text_classifier_core.f
hdl/ipac_pkg.sv
hdl/ipac_front.sv
hdl/ipac_cq.sv
hdl/ipac_back.sv
hdl/ip_address_text_classifier_core.sv
sim/tb_ip_address_text_classifier_core.sv
